@@ rtl/rmst_pkg.sv @@
`default_nettype none

package rmst_pkg;

	// default sizing
	localparam int DEPTH_DEF       = 1024;
	localparam int LEVELS_DEF      = 11;
	localparam int VALUE_WIDTH_DEF = 32;

	// fixed field widths
	localparam int ELEM_W = 32;
	localparam int IDX_W  = 10;
	localparam int LEN_W  = IDX_W + 1;
	localparam int LOG_W  = $clog2(LEN_W);

	typedef enum logic {
		ACT_LOAD  = 1'b0,
		ACT_QUERY = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_BUILT = 2'd1,
		ST_BAD_RANGE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_BUILD_RD,
		S_BUILD_WR,
		S_QUERY_RD,
		S_RESULT
	} seq_state_t;

	// table memory control from sequencer
	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} mem_ctl_t;

	// position of the highest set bit, zero for zero
	function automatic logic [LOG_W-1:0] floor_log2(input logic [LEN_W-1:0] v);
		logic [LOG_W-1:0] r;
		r = '0;
		for (int i = 0; i < LEN_W; i++) begin
			if (v[i]) r = LOG_W'(i);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/rmst_ram.sv @@
`default_nettype none

module rmst_ram #(
	parameter int WORDS = 16,
	parameter int AW    = 4,
	parameter int DW    = 32
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr_a,
	input  wire logic [AW-1:0] rd_addr_b,
	output logic      [DW-1:0] rd_data_a,
	output logic      [DW-1:0] rd_data_b
);

	logic [DW-1:0] mem_q [0:WORDS-1];

	// single write port
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
	end

	// two registered read ports
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem_q[rd_addr_a];
			rd_data_b <= mem_q[rd_addr_b];
		end
	end

endmodule

`default_nettype wire

@@ rtl/rmst_max.sv @@
`default_nettype none

module rmst_max #(
	parameter int VW = 32
) (
	input  wire logic [VW-1:0] a,
	input  wire logic [VW-1:0] b,
	output logic      [VW-1:0] y
);

	// signed compare, first operand wins a tie
	assign y = ($signed(a) >= $signed(b)) ? a : b;

endmodule

`default_nettype wire

@@ rtl/rmst_seq.sv @@
`default_nettype none

module rmst_seq #(
	parameter int DEPTH  = rmst_pkg::DEPTH_DEF,
	parameter int LEVELS = rmst_pkg::LEVELS_DEF,
	parameter int VW     = rmst_pkg::VALUE_WIDTH_DEF,
	parameter int PW     = $clog2(DEPTH),
	parameter int LL     = $clog2(LEVELS),
	parameter int AW     = LL + PW
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic                             action,
	input  wire logic signed [rmst_pkg::ELEM_W-1:0] element_value,
	input  wire logic                             is_last,
	input  wire logic        [rmst_pkg::IDX_W-1:0] left_index,
	input  wire logic        [rmst_pkg::IDX_W-1:0] right_index,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic signed      [rmst_pkg::ELEM_W-1:0] max_value,
	output logic             [1:0]                status,
	output rmst_pkg::mem_ctl_t                    mem_ctl,
	output logic             [AW-1:0]             wr_addr,
	output logic             [VW-1:0]             wr_data,
	output logic             [AW-1:0]             rd_addr_a,
	output logic             [AW-1:0]             rd_addr_b,
	input  wire logic        [VW-1:0]             max_res
);

	localparam int CW  = $clog2(DEPTH + 1);
	localparam int LJW = $clog2(LEVELS + 1);
	localparam int SW  = ((CW > LEVELS) ? CW : LEVELS) + 1;
	localparam int QW  = (CW > rmst_pkg::IDX_W) ? CW : rmst_pkg::IDX_W;
	localparam int IW  = (PW > rmst_pkg::LEN_W) ? PW : rmst_pkg::LEN_W;

	rmst_pkg::seq_state_t state_q, state_d;
	rmst_pkg::status_t    stat_q, q_stat;

	logic [CW-1:0]  count_q, eff_count;
	logic           built_q;
	logic [LJW-1:0] lvl_q;
	logic [PW-1:0]  idx_q;
	logic [rmst_pkg::IDX_W-1:0] left_q, right_q;
	logic           out_valid_q;
	logic [rmst_pkg::ELEM_W-1:0] max_q;
	logic [1:0]     status_q;

	logic accept, is_load, can_store, bad_range, slot_free;
	logic [SW-1:0]  pow_j, half_j, cnt_ext, idx_half;
	logic           level_ok, entry_ok;
	logic [LJW-1:0] lvl_prev;
	logic [rmst_pkg::LEN_W-1:0] len, second, pow_k;
	logic [rmst_pkg::LOG_W-1:0] k_raw;
	logic [LL-1:0]  k;
	logic [IW-1:0]  left_ext, second_ext;

	assign accept    = in_valid && in_ready;
	assign is_load   = (rmst_pkg::action_t'(action) == rmst_pkg::ACT_LOAD);
	assign eff_count = built_q ? '0 : count_q;
	assign can_store = (eff_count < CW'(DEPTH));
	assign slot_free = !out_valid_q || out_ready;

	// query range check against the loaded length
	assign bad_range = (left_index > right_index) || (QW'(right_index) >= QW'(count_q));
	assign q_stat    = !built_q ? rmst_pkg::ST_NOT_BUILT :
	                   bad_range ? rmst_pkg::ST_BAD_RANGE : rmst_pkg::ST_OK;

	// build loop bounds
	assign pow_j    = SW'(1) << lvl_q;
	assign half_j   = pow_j >> 1;
	assign cnt_ext  = SW'(count_q);
	assign level_ok = (lvl_q < LJW'(LEVELS)) && (pow_j <= cnt_ext);
	assign entry_ok = (SW'(idx_q) + pow_j) <= cnt_ext;
	assign idx_half = SW'(idx_q) + half_j;
	assign lvl_prev = lvl_q - LJW'(1);

	// query level and second window start
	assign len   = rmst_pkg::LEN_W'(right_q) - rmst_pkg::LEN_W'(left_q)
	             + rmst_pkg::LEN_W'(1);
	assign k_raw = rmst_pkg::floor_log2(len);
	always_comb begin
		if (32'(k_raw) > LEVELS - 1) k = LL'(LEVELS - 1);
		else k = LL'(k_raw);
	end
	assign pow_k      = rmst_pkg::LEN_W'(1) << k;
	assign second     = rmst_pkg::LEN_W'(right_q) + rmst_pkg::LEN_W'(1) - pow_k;
	assign left_ext   = IW'(left_q);
	assign second_ext = IW'(second);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rmst_pkg::S_IDLE: begin
				if (accept) begin
					if (is_load) begin
						if (is_last) state_d = rmst_pkg::S_BUILD_RD;
					end else if (q_stat == rmst_pkg::ST_OK) begin
						state_d = rmst_pkg::S_QUERY_RD;
					end else begin
						state_d = rmst_pkg::S_RESULT;
					end
				end
			end
			rmst_pkg::S_BUILD_RD: begin
				if (!level_ok) state_d = rmst_pkg::S_IDLE;
				else if (entry_ok) state_d = rmst_pkg::S_BUILD_WR;
			end
			rmst_pkg::S_BUILD_WR: state_d = rmst_pkg::S_BUILD_RD;
			rmst_pkg::S_QUERY_RD: state_d = rmst_pkg::S_RESULT;
			rmst_pkg::S_RESULT: begin
				if (slot_free) state_d = rmst_pkg::S_IDLE;
			end
			default: state_d = rmst_pkg::S_IDLE;
		endcase
	end

	// outputs and memory control
	always_comb begin
		in_ready      = 1'b0;
		mem_ctl.rd_en = 1'b0;
		mem_ctl.wr_en = 1'b0;
		wr_addr       = {{LL{1'b0}}, eff_count[PW-1:0]};
		wr_data       = VW'(element_value);
		rd_addr_a     = {lvl_prev[LL-1:0], idx_q};
		rd_addr_b     = {lvl_prev[LL-1:0], idx_half[PW-1:0]};
		case (state_q)
			rmst_pkg::S_IDLE: begin
				in_ready      = 1'b1;
				mem_ctl.wr_en = in_valid && is_load && can_store;
			end
			rmst_pkg::S_BUILD_RD: begin
				mem_ctl.rd_en = level_ok && entry_ok;
			end
			rmst_pkg::S_BUILD_WR: begin
				mem_ctl.wr_en = 1'b1;
				wr_addr       = {lvl_q[LL-1:0], idx_q};
				wr_data       = max_res;
			end
			rmst_pkg::S_QUERY_RD: begin
				mem_ctl.rd_en = 1'b1;
				rd_addr_a     = {k, left_ext[PW-1:0]};
				rd_addr_b     = {k, second_ext[PW-1:0]};
			end
			default: ;
		endcase
	end

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rmst_pkg::S_IDLE;
			count_q     <= '0;
			built_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && is_load) begin
				built_q <= 1'b0;
				count_q <= can_store ? eff_count + CW'(1) : eff_count;
			end
			if (state_q == rmst_pkg::S_BUILD_RD && !level_ok) built_q <= 1'b1;
			if (state_q == rmst_pkg::S_RESULT && slot_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// loop counters, request fields and result
	always_ff @(posedge clk) begin
		case (state_q)
			rmst_pkg::S_IDLE: begin
				lvl_q   <= LJW'(1);
				idx_q   <= '0;
				left_q  <= left_index;
				right_q <= right_index;
				stat_q  <= q_stat;
			end
			rmst_pkg::S_BUILD_RD: begin
				if (level_ok && !entry_ok) begin
					lvl_q <= lvl_q + LJW'(1);
					idx_q <= '0;
				end
			end
			rmst_pkg::S_BUILD_WR: idx_q <= idx_q + PW'(1);
			rmst_pkg::S_RESULT: begin
				if (slot_free) begin
					max_q    <= (stat_q == rmst_pkg::ST_OK) ?
					            rmst_pkg::ELEM_W'(max_res) : '0;
					status_q <= stat_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign max_value = max_q;
	assign status    = status_q;

endmodule

`default_nettype wire

@@ rtl/range_max_sparse_table_top.sv @@
// Range-maximum engine over a sparse table held in one two-read, one-write
// memory of LEVELS*2^clog2(DEPTH) words (11264 for the defaults), with no
// clearing pass after reset. A load marked last builds the table through a
// single shared signed max unit, with a read state and a write state per
// table entry, a step to the next level at the end of each level and a
// final step to finish, and with no request taken meanwhile. A query request
// passes through accept, memory read, and max and result, skipping the
// memory read when its status is an error; the memory read is registered.
// Results leave through an output register, so the next request is taken
// while a result waits. Loads past DEPTH are dropped.
`default_nettype none

module range_max_sparse_table_top #(
	parameter int DEPTH       = rmst_pkg::DEPTH_DEF,
	parameter int LEVELS      = rmst_pkg::LEVELS_DEF,
	parameter int VALUE_WIDTH = rmst_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic                               action,
	input  wire logic signed [rmst_pkg::ELEM_W-1:0] element_value,
	input  wire logic                               is_last,
	input  wire logic        [rmst_pkg::IDX_W-1:0]  left_index,
	input  wire logic        [rmst_pkg::IDX_W-1:0]  right_index,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic signed      [rmst_pkg::ELEM_W-1:0] max_value,
	output logic             [1:0]                  status
);

	localparam int PW    = $clog2(DEPTH);
	localparam int LL    = $clog2(LEVELS);
	localparam int AW    = LL + PW;
	localparam int WORDS = LEVELS * (2 ** PW);

	rmst_pkg::mem_ctl_t mem_ctl;
	logic [AW-1:0]          wr_addr, rd_addr_a, rd_addr_b;
	logic [VALUE_WIDTH-1:0] wr_data, rd_data_a, rd_data_b, max_res;

	// sequencer
	rmst_seq #(
		.DEPTH (DEPTH),
		.LEVELS(LEVELS),
		.VW    (VALUE_WIDTH),
		.PW    (PW),
		.LL    (LL),
		.AW    (AW)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.element_value(element_value),
		.is_last      (is_last),
		.left_index   (left_index),
		.right_index  (right_index),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.max_value    (max_value),
		.status       (status),
		.mem_ctl      (mem_ctl),
		.wr_addr      (wr_addr),
		.wr_data      (wr_data),
		.rd_addr_a    (rd_addr_a),
		.rd_addr_b    (rd_addr_b),
		.max_res      (max_res)
	);

	// table storage
	rmst_ram #(
		.WORDS(WORDS),
		.AW   (AW),
		.DW   (VALUE_WIDTH)
	) u_ram (
		.clk      (clk),
		.wr_en    (mem_ctl.wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (mem_ctl.rd_en),
		.rd_addr_a(rd_addr_a),
		.rd_addr_b(rd_addr_b),
		.rd_data_a(rd_data_a),
		.rd_data_b(rd_data_b)
	);

	// shared max unit for build and query
	rmst_max #(
		.VW(VALUE_WIDTH)
	) u_max (
		.a(rd_data_a),
		.b(rd_data_b),
		.y(max_res)
	);

	// checks
	a_rd_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mem_ctl.rd_en |-> !in_ready)
		else $error("table read while taking requests");

	a_build_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (action == rmst_pkg::ACT_LOAD) && is_last) |=> !in_ready)
		else $error("request taken during table build");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != rmst_pkg::ST_OK) |-> (max_value == '0))
		else $error("nonzero value with error status");

	a_no_wr_on_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_ctl.rd_en && mem_ctl.wr_en) |-> 1'b0)
		else $error("table read and write in one cycle");

endmodule

`default_nettype wire

@@ dv/range_max_sparse_table_top_test.sv @@
`timescale 1ns / 1ps

module range_max_sparse_table_top_test;

	localparam int DEPTH          = rmst_pkg::DEPTH_DEF;
	localparam int ELEM_W         = rmst_pkg::ELEM_W;
	localparam int IDX_W          = rmst_pkg::IDX_W;
	localparam int ITEM_TARGET    = 1350;
	// full depth array with dropped loads and the queries that follow it
	localparam int FULL_ITEMS     = DEPTH + 3 + 4 + 40;
	localparam int WATCHDOG_LIMIT = 200000;
	localparam int DRAIN_CYCLES   = 64;

	localparam logic signed [ELEM_W-1:0] MOST_NEG = {1'b1, {(ELEM_W-1){1'b0}}};
	localparam logic signed [ELEM_W-1:0] MOST_POS = {1'b0, {(ELEM_W-1){1'b1}}};

	typedef struct {
		logic signed [ELEM_W-1:0] max_value;
		rmst_pkg::status_t        status;
	} range_answer_t;

	// array shadow plus the answers still owed by the block
	class range_max_board;
		logic signed [ELEM_W-1:0] elements [DEPTH];
		int                       elem_count;
		bit                       built;
		range_answer_t            pending_answers [$];
		int                       mismatches;

		function new();
			elem_count = 0;
			built      = 1'b0;
			mismatches = 0;
		endfunction

		// accepted request: append an element or queue the expected answer
		function void note_request(rmst_pkg::action_t act, logic signed [ELEM_W-1:0] value,
				logic last, logic [IDX_W-1:0] lo, logic [IDX_W-1:0] hi);
			range_answer_t ans;
			ans.max_value = '0;
			ans.status    = rmst_pkg::ST_OK;
			if (act == rmst_pkg::ACT_LOAD) begin
				// a load after a build starts a fresh array
				if (built) begin
					built      = 1'b0;
					elem_count = 0;
				end
				// loads past the depth are dropped
				if (elem_count < DEPTH) begin
					elements[elem_count] = value;
					elem_count++;
				end
				if (last)
					built = 1'b1;
			end else begin
				if (!built) begin
					ans.status = rmst_pkg::ST_NOT_BUILT;
				end else if (lo > hi || int'(hi) >= elem_count) begin
					ans.status = rmst_pkg::ST_BAD_RANGE;
				end else begin
					ans.max_value = elements[lo];
					for (int i = int'(lo) + 1; i <= int'(hi); i++)
						if (elements[i] > ans.max_value)
							ans.max_value = elements[i];
				end
				pending_answers.push_back(ans);
			end
		endfunction

		// accepted result against the oldest expected answer
		function void check_result(logic signed [ELEM_W-1:0] value, logic [1:0] code);
			range_answer_t want;
			if (pending_answers.size() == 0) begin
				$display("%0t: result with no query outstanding: max_value %0d status %0d",
					$time, value, code);
				mismatches++;
			end else begin
				want = pending_answers.pop_front();
				if (value !== want.max_value) begin
					$display("%0t: max_value mismatch: expected %0d, actual %0d",
						$time, want.max_value, value);
					mismatches++;
				end
				if (code !== want.status) begin
					$display("%0t: status mismatch: expected %0d, actual %0d",
						$time, want.status, code);
					mismatches++;
				end
			end
		endfunction
	endclass

	logic                     clk           = 1'b0;
	logic                     arst_n        = 1'b0;
	logic                     in_valid      = 1'b0;
	logic                     in_ready;
	logic                     action        = rmst_pkg::ACT_LOAD;
	logic signed [ELEM_W-1:0] element_value = '0;
	logic                     is_last       = 1'b0;
	logic        [IDX_W-1:0]  left_index    = '0;
	logic        [IDX_W-1:0]  right_index   = '0;
	logic                     out_valid;
	logic                     out_ready     = 1'b1;
	logic signed [ELEM_W-1:0] max_value;
	logic        [1:0]        status;

	range_max_board board;
	int             items_sent   = 0;
	int             burst_left   = 0;
	int             carried_len  = 0;
	int             quiet_cycles = 0;
	int             stall_tick   = 0;
	int             stall_mode   = 0;

	range_max_sparse_table_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.element_value(element_value),
		.is_last      (is_last),
		.left_index   (left_index),
		.right_index  (right_index),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.max_value    (max_value),
		.status       (status)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver stalls: out_ready always high, random, or in a repeating pattern, by a mode picked at random
	always @(negedge clk) begin
		if (stall_tick % 256 == 0)
			stall_mode = $urandom_range(0, 2);
		stall_tick++;
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			default: out_ready <= ((stall_tick % 11) >= 6);
		endcase
	end

	// monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				board.check_result(max_value, status);
			if (in_valid && in_ready)
				board.note_request(rmst_pkg::action_t'(action), element_value, is_last,
					left_index, right_index);
			if ((out_valid && out_ready) || (in_valid && in_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("[range_max_sparse_table_top] ERROR");
				$finish;
			end
		end
	end

	// one request, then either stay in the burst or leave a gap
	task automatic send_request(rmst_pkg::action_t act, logic signed [ELEM_W-1:0] value,
			logic last, logic [IDX_W-1:0] lo, logic [IDX_W-1:0] hi);
		int gap;
		@(negedge clk);
		in_valid      <= 1'b1;
		action        <= act;
		element_value <= value;
		is_last       <= last;
		left_index    <= lo;
		right_index   <= hi;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 8);
			@(negedge clk);
			in_valid      <= 1'b0;
			element_value <= $urandom;
			repeat (gap - 1) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
				: $urandom_range(0, 12);
		end
	endtask

	task automatic send_load(logic signed [ELEM_W-1:0] value, logic last);
		send_request(rmst_pkg::ACT_LOAD, value, last, IDX_W'($urandom), IDX_W'($urandom));
	endtask

	// unused fields of a query carry random bits
	task automatic send_query(int lo, int hi);
		send_request(rmst_pkg::ACT_QUERY, $urandom, 1'($urandom), IDX_W'(lo), IDX_W'(hi));
	endtask

	function automatic logic signed [ELEM_W-1:0] rand_element();
		case ($urandom_range(0, 9))
			0: return MOST_NEG;
			1: return MOST_POS;
			2, 3: return ELEM_W'($urandom_range(0, 8)) - ELEM_W'(4);
			default: return $urandom;
		endcase
	endfunction

	// queries over an array of len elements: mostly in range, some malformed
	task automatic send_query_mix(int count, int len);
		int lo;
		int hi;
		for (int q = 0; q < count; q++) begin
			case ($urandom_range(0, 9))
				0: begin
					lo = 0;
					hi = len - 1;
				end
				1: begin
					lo = $urandom_range(1, 1023);
					hi = $urandom_range(0, lo - 1);
				end
				2: begin
					hi = (len < 1024) ? $urandom_range(len, 1023) : 1023;
					lo = $urandom_range(0, hi);
				end
				3: begin
					lo = $urandom_range(0, 1023);
					hi = $urandom_range(0, 1023);
				end
				default: begin
					lo = $urandom_range(0, len - 1);
					hi = $urandom_range(lo, len - 1);
				end
			endcase
			send_query(lo, hi);
		end
	endtask

	// load an array with the odd stray query, then query it
	task automatic run_random_array(int n, int queries, bit mark_last);
		int len;
		for (int i = 0; i < n; i++) begin
			if (i > 0 && $urandom_range(0, 15) == 0)
				send_query($urandom_range(0, 1023), $urandom_range(0, 1023));
			send_load(rand_element(), mark_last && (i == n - 1));
		end
		// an unterminated array keeps growing with the next one
		len = carried_len + n;
		if (len > DEPTH)
			len = DEPTH;
		carried_len = mark_last ? 0 : len;
		send_query_mix(queries, len);
	endtask

	initial begin
		board = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// query straight after reset
		send_query(0, 0);

		// extremes of the element value
		send_load(MOST_NEG, 1'b0);
		send_load(MOST_POS, 1'b0);
		send_load('0, 1'b0);
		send_load(-1, 1'b1);
		send_query(0, 3);
		send_query(0, 0);
		send_query(2, 3);
		send_query(3, 3);
		send_query(1, 0);
		send_query(0, 4);
		send_query(1023, 1023);
		send_query(0, 1023);

		// load after a build starts a fresh array
		send_load(5, 1'b0);
		send_query(0, 0);
		send_load(7, 1'b1);
		send_query(0, 1);
		send_query(1, 1);

		// single element array
		send_load(-5, 1'b1);
		send_query(0, 0);
		send_query(0, 1);

		// random arrays, mostly small, a few left unterminated
		while (items_sent < ITEM_TARGET - FULL_ITEMS) begin
			run_random_array(($urandom_range(0, 4) == 0) ? $urandom_range(33, 128)
				: $urandom_range(1, 32), $urandom_range(4, 24),
				$urandom_range(0, 9) != 0);
		end

		// full depth array, then loads that are dropped
		for (int i = 0; i < DEPTH + 3; i++)
			send_load((i < DEPTH) ? rand_element() : MOST_POS, i == DEPTH + 2);
		send_query(0, DEPTH - 1);
		send_query(DEPTH - 1, DEPTH - 1);
		send_query(0, 0);
		send_query(1, DEPTH - 1);
		send_query_mix(40, DEPTH);

		// drain
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.pending_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (board.mismatches == 0 && board.pending_answers.size() == 0)
			$display("[range_max_sparse_table_top] OK");
		else
			$display("[range_max_sparse_table_top] ERROR");
		$finish;
	end

endmodule
